@@ rtl/core/wcg_pkg.sv @@
// ----------------------------------------------------------------------------
// wcg_pkg
// Shared types, widths and helpers of the window convolution with gain unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wcg_pkg;

    // kernel geometry
    localparam int MAX_KERNEL_SIDE = 7;
    localparam int STORE_DEPTH     = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int TOTAL_W         = $clog2(STORE_DEPTH + 1);
    localparam int SIDE_W          = $clog2(MAX_KERNEL_SIDE + 1);

    // field widths
    localparam int KIND_W     = 1;
    localparam int INDEX_W    = 6;
    localparam int COEF_W     = 20;
    localparam int SAMPLE_W   = 24;
    localparam int SIDE_REG_W = 3;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 56;
    localparam int VALUE_W    = 32;

    // stream packing
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;
    localparam int OFS_INDEX  = 0;
    localparam int OFS_COEF   = OFS_INDEX + INDEX_W;
    localparam int OFS_SAMPLE = OFS_COEF + COEF_W;
    localparam int OFS_UNDEF  = OFS_SAMPLE + SAMPLE_W;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [SIDE_REG_W-1:0] ROWS_RESET    = 3'd3;
    localparam logic [SIDE_REG_W-1:0] COLUMNS_RESET = 3'd3;
    localparam logic [GAIN_W-1:0]     GAIN_RESET    = 24'd1048576;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_ROWS    = 2'd0,
        REG_KERNEL_COLUMNS = 2'd1,
        REG_GAIN           = 2'd2
    } wcg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_COEF   = 1'b0,
        KIND_SAMPLE = 1'b1
    } wcg_kind_t;

    // one classified item
    typedef struct packed {
        logic                       is_sample;
        logic [ADDR_W-1:0]          addr;
        logic signed [COEF_W-1:0]   coef;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       mac_en;
        logic                       last;
        logic                       undef;
    } wcg_item_t;

    // finished window handed to the scaler
    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] acc;
        logic                    undef;
    } wcg_scale_req_t;

    // odd side in use, clamped to the largest kernel
    function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_REG_W-1:0] v);
        logic [SIDE_REG_W:0] s;
        s = {1'b0, v | SIDE_REG_W'(1)};
        if (int'(s) > MAX_KERNEL_SIDE) begin
            return SIDE_W'(MAX_KERNEL_SIDE);
        end
        return SIDE_W'(s);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wcg_front.sv @@
// ----------------------------------------------------------------------------
// wcg_front
// Accepts input transactions, tracks window position and the undefined mark,
// and pushes classified items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // coef_index, coef_value, sample, sample_undefined, zero fill
    input  wire logic [wcg_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  wire logic [wcg_pkg::KIND_W-1:0]       s_tuser,
    input  wire logic [wcg_pkg::SIDE_REG_W-1:0]   kernel_rows,
    input  wire logic [wcg_pkg::SIDE_REG_W-1:0]   kernel_columns,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output wcg_pkg::wcg_item_t                    q_item
);
    import wcg_pkg::*;

    logic [ADDR_W-1:0]          pos_reg, pos_next;
    logic                       undef_seen_reg, undef_seen_next;
    logic                       accept;
    logic                       is_sample;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_undefined;
    logic [TOTAL_W-1:0]         total;
    logic [TOTAL_W-1:0]         pos_inc;
    logic                       last;
    logic                       seen_now;
    logic                       index_ok;

    // field unpacking
    assign coef_index       = s_tdata[OFS_INDEX +: INDEX_W];
    assign coef_value       = s_tdata[OFS_COEF +: COEF_W];
    assign sample           = s_tdata[OFS_SAMPLE +: SAMPLE_W];
    assign sample_undefined = s_tdata[OFS_UNDEF];
    assign is_sample        = (wcg_kind_t'(s_tuser) == KIND_SAMPLE);

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // window bookkeeping
    assign total    = TOTAL_W'(side_in_use(kernel_rows)) *
                      TOTAL_W'(side_in_use(kernel_columns));
    assign pos_inc  = TOTAL_W'(pos_reg) + TOTAL_W'(1);
    assign last     = (pos_inc >= total);
    assign seen_now = undef_seen_reg || sample_undefined;
    assign index_ok = (int'(coef_index) < STORE_DEPTH);

    always_comb begin
        pos_next        = pos_reg;
        undef_seen_next = undef_seen_reg;
        if (accept && is_sample) begin
            if (last) begin
                pos_next        = '0;
                undef_seen_next = 1'b0;
            end else begin
                pos_next        = ADDR_W'(pos_inc);
                undef_seen_next = seen_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            undef_seen_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            undef_seen_reg <= undef_seen_next;
        end
    end

    // classified item; loads beyond the store are dropped
    always_comb begin
        q_push           = accept && (is_sample || index_ok);
        q_item.is_sample = is_sample;
        q_item.addr      = is_sample ? pos_reg : ADDR_W'(coef_index);
        q_item.coef      = coef_value;
        q_item.sample    = sample;
        q_item.mac_en    = !seen_now;
        q_item.last      = last;
        q_item.undef     = seen_now;
    end

endmodule

`default_nettype wire

@@ rtl/core/wcg_queue.sv @@
// ----------------------------------------------------------------------------
// wcg_queue
// Short FIFO that decouples the front from the multiply-accumulate back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wcg_pkg::wcg_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output wcg_pkg::wcg_item_t     head_item
);
    import wcg_pkg::*;

    wcg_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (int'(count_reg) == QUEUE_DEPTH);
    assign valid     = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/wcg_back.sv @@
// ----------------------------------------------------------------------------
// wcg_back
// Coefficient store and multiply-accumulate pipeline: store read, product,
// accumulate, and hand-off of each finished window to the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire wcg_pkg::wcg_item_t    q_item,
    output logic                       q_pop,
    input  wire logic                  scale_ready,
    output wcg_pkg::wcg_scale_req_t    scale_req
);
    import wcg_pkg::*;

    logic signed [COEF_W-1:0]   coef_mem [STORE_DEPTH];

    logic                       s1_valid_reg;
    logic signed [COEF_W-1:0]   s1_coef_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_mac_en_reg, s1_last_reg, s1_undef_reg;

    logic                       s2_valid_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic                       s2_mac_en_reg, s2_last_reg, s2_undef_reg;

    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       adv;

    // the pipeline holds while a finished window waits for the scaler
    assign adv   = !(s2_valid_reg && s2_last_reg && !scale_ready);
    assign q_pop = q_valid && adv;

    assign acc_next = acc_reg + (s2_mac_en_reg ? ACC_W'(s2_prod_reg) : '0);

    always_comb begin
        scale_req.start = s2_valid_reg && s2_last_reg && adv;
        scale_req.acc   = acc_next;
        scale_req.undef = s2_undef_reg;
    end

    // coefficient store: load writes, sample reads
    always_ff @(posedge aclk) begin
        if (q_pop && !q_item.is_sample) begin
            coef_mem[q_item.addr] <= q_item.coef;
        end
        if (adv) begin
            s1_coef_reg <= coef_mem[q_item.addr];
        end
    end

    // pipeline control and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end else if (adv) begin
            s1_valid_reg <= q_pop && q_item.is_sample;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg) begin
                acc_reg <= s2_last_reg ? '0 : acc_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sample_reg <= q_item.sample;
            s1_mac_en_reg <= q_item.mac_en;
            s1_last_reg   <= q_item.last;
            s1_undef_reg  <= q_item.undef;
            s2_prod_reg   <= s1_sample_reg * s1_coef_reg;
            s2_mac_en_reg <= s1_mac_en_reg;
            s2_last_reg   <= s1_last_reg;
            s2_undef_reg  <= s1_undef_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // a window hand-off leaves the accumulator cleared
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        scale_req.start |=> (acc_reg == '0))
        else $error("accumulator not cleared after window hand-off");

    // a stalled sample stays in the first stage
    a_s1_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("sample lost while back end stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/core/wcg_scale.sv @@
// ----------------------------------------------------------------------------
// wcg_scale
// Multi-cycle gain scaler: magnitude, two partial products, rounding and
// saturation, then the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_scale (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire wcg_pkg::wcg_scale_req_t       req,
    input  wire logic [wcg_pkg::GAIN_W-1:0]    gain,
    output logic                               ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // value
    output logic [wcg_pkg::M_TDATA_W-1:0]      m_tdata,
    // undefined
    output logic                               m_tuser
);
    import wcg_pkg::*;

    localparam int HI_W  = ACC_W - GAIN_W;
    localparam int HP_W  = HI_W + GAIN_W;
    localparam int LP_W  = 2 * GAIN_W;
    localparam int X_W   = HP_W + 1;
    localparam int Q_W   = X_W - 12;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAG  = 5'b00010,
        S_HI   = 5'b00100,
        S_LO   = 5'b01000,
        S_SUM  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    undef_reg;
    logic [ACC_W-1:0]        amag_reg;
    logic [GAIN_W-1:0]       gmag_reg;
    logic                    neg_reg;
    logic [HP_W-1:0]         hi_reg;
    logic [LP_W-1:0]         lo_reg;
    logic                    out_valid_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic                    out_undef_reg;

    logic                    out_free;
    logic [LP_W:0]           lo_rnd;
    logic [X_W-1:0]          x;
    logic [Q_W-1:0]          q;
    logic                    q_big;
    logic [VALUE_W-1:0]      value_sat;

    assign ready    = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_undef_reg;

    // rounding to nearest, ties away from zero, then saturation
    assign lo_rnd = {1'b0, lo_reg} + ((LP_W + 1)'(1) << 35);
    assign x      = {1'b0, hi_reg} + X_W'(lo_rnd[LP_W:24]);
    assign q      = x[X_W-1:12];
    assign q_big  = |q[Q_W-1:VALUE_W-1];

    always_comb begin
        if (neg_reg) begin
            value_sat = q_big ? {1'b1, {(VALUE_W - 1){1'b0}}}
                              : (VALUE_W'(0) - q[VALUE_W-1:0]);
        end else begin
            value_sat = q_big ? {1'b0, {(VALUE_W - 1){1'b1}}} : q[VALUE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.start) state_next = S_MAG;
            S_MAG:   state_next = S_HI;
            S_HI:    state_next = S_LO;
            S_LO:    state_next = S_SUM;
            S_SUM:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_SUM && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && req.start) begin
            acc_reg   <= req.acc;
            undef_reg <= req.undef;
        end
        if (state_reg == S_MAG) begin
            amag_reg <= acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
            gmag_reg <= gain[GAIN_W-1] ? (~gain + GAIN_W'(1)) : gain;
            neg_reg  <= acc_reg[ACC_W-1] != gain[GAIN_W-1];
        end
        if (state_reg == S_HI) begin
            hi_reg <= HP_W'(amag_reg[ACC_W-1:GAIN_W]) * HP_W'(gmag_reg);
        end
        if (state_reg == S_LO) begin
            lo_reg <= LP_W'(amag_reg[GAIN_W-1:0]) * LP_W'(gmag_reg);
        end
        if (state_reg == S_SUM && out_free) begin
            out_value_reg <= undef_reg ? '0 : value_sat;
            out_undef_reg <= undef_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // new windows arrive only while the scaler is free
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == S_IDLE))
        else $error("window handed to busy scaler");

    // an undefined window carries a zero value
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("undefined result with nonzero value");

    // a result only appears from the final step
    a_out_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_SUM))
        else $error("result written outside the final step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/window_convolution_with_gain_unit.sv @@
// ----------------------------------------------------------------------------
// window_convolution_with_gain_unit
// Linear 2D window filter: coefficient loads and window samples in, one
// scaled, rounded and saturated sum out per completed window.
// ----------------------------------------------------------------------------
//  channel   ports               transaction
//  ------    -----------------   ------------------------------------------
//  input     s_tvalid/s_tready   kind in s_tuser, load or sample in s_tdata
//  result    m_tvalid/m_tready   value in m_tdata, undefined in m_tuser
//  config    cfg_wr_en           kernel_rows, kernel_columns, gain
//
//  A sample or a coefficient load is taken every cycle while the queue has
//  room; the multiply-accumulate pipeline registers the store read and the
//  product. The end of each window runs the gain scaler through magnitude,
//  two partial products, round and saturate; it takes no new window until
//  it is back in idle, and a window that ends sooner holds the pipeline.
//  Reset is synchronous, active low; the coefficient store is not cleared.
//  A stalled result channel holds the scaler, then the pipeline and the
//  queue, and finally drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module window_convolution_with_gain_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // coef_index, coef_value, sample, sample_undefined, zero fill
    input  wire logic [wcg_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire logic [wcg_pkg::KIND_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // value
    output logic [wcg_pkg::M_TDATA_W-1:0]          m_tdata,
    // undefined
    output logic                                   m_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [wcg_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [wcg_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import wcg_pkg::*;

    logic [SIDE_REG_W-1:0] kernel_rows_reg;
    logic [SIDE_REG_W-1:0] kernel_columns_reg;
    logic [GAIN_W-1:0]     gain_reg;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    wcg_item_t             push_item;
    wcg_item_t             head_item;
    logic                  scale_ready;
    wcg_scale_req_t        scale_req;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_rows_reg    <= ROWS_RESET;
            kernel_columns_reg <= COLUMNS_RESET;
            gain_reg           <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (wcg_reg_t'(cfg_wr_index))
                REG_KERNEL_ROWS:    kernel_rows_reg    <= cfg_wr_data[SIDE_REG_W-1:0];
                REG_KERNEL_COLUMNS: kernel_columns_reg <= cfg_wr_data[SIDE_REG_W-1:0];
                REG_GAIN:           gain_reg           <= cfg_wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    wcg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .kernel_rows    (kernel_rows_reg),
        .kernel_columns (kernel_columns_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    wcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    wcg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .scale_ready (scale_ready),
        .scale_req   (scale_req)
    );

    wcg_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (scale_req),
        .gain     (gain_reg),
        .ready    (scale_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ verif/tb_window_convolution_with_gain_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_convolution_with_gain_unit
// Self-checking bench for the window filter: a directed table of loads and
// windows, then random phases over several kernel shapes and gains. Each
// accepted input transaction runs through a local filter predictor, and
// every result transaction is compared against the oldest expected sum.
// ----------------------------------------------------------------------------

module tb_window_convolution_with_gain_unit;

    import wcg_pkg::*;

    localparam int NUM_PHASES        = 8;
    localparam int ITEMS_PER_PHASE   = 134;
    localparam int DIRECTED_ROWS     = 28;
    localparam int SETTLE_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int REPORT_LIMIT      = 10;

    // one expected or observed result transaction
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               undef;
    } window_result_t;

    // one row of the directed table
    typedef struct packed {
        wcg_kind_t           kind;
        logic [INDEX_W-1:0]  idx;
        logic [COEF_W-1:0]   coef;
        logic [SAMPLE_W-1:0] smp;
        logic                undef;
        logic                typed;
        logic [VALUE_W-1:0]  want_value;
        logic                want_undef;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    // coef_index, coef_value, sample, sample_undefined, zero fill
    logic [S_TDATA_W-1:0]     s_tdata;
    // kind
    logic [KIND_W-1:0]        s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // value
    logic [M_TDATA_W-1:0]     m_tdata;
    // undefined
    logic                     m_tuser;
    logic                     cfg_wr_en;
    logic [CFG_INDEX_W-1:0]   cfg_wr_index;
    logic [CFG_DATA_W-1:0]    cfg_wr_data;

    // predictor state
    logic [COEF_W-1:0]     kernel_store [STORE_DEPTH];
    logic [ACC_W-1:0]      window_acc;
    int unsigned           window_pos;
    bit                    window_undef;
    logic [SIDE_REG_W-1:0] rows_model;
    logic [SIDE_REG_W-1:0] cols_model;
    logic [GAIN_W-1:0]     gain_model;

    window_result_t window_sums_due [$];
    int unsigned    error_count;
    bit             source_idling;
    bit             sink_idling;
    bit             hold_results;
    stim_row_t      directed_rows [DIRECTED_ROWS];

    window_convolution_with_gain_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // odd side actually used by the window, clamped to the store geometry
    function automatic int unsigned side_used(input logic [SIDE_REG_W-1:0] v);
        int unsigned s;
        s = int'(v | SIDE_REG_W'(1));
        return (s > MAX_KERNEL_SIDE) ? MAX_KERNEL_SIDE : s;
    endfunction

    // acc (Q.16) times gain (Q4.20), rounded half away from zero, saturated
    function automatic logic [VALUE_W-1:0] scale_window_sum(input logic [ACC_W-1:0] acc,
                                                           input logic [GAIN_W-1:0] g);
        logic [ACC_W-1:0]  acc_mag;
        logic [GAIN_W-1:0] gain_mag;
        logic [79:0]       rounded;
        bit                neg;
        acc_mag  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
        gain_mag = g[GAIN_W-1] ? (~g + GAIN_W'(1)) : g;
        neg      = acc[ACC_W-1] ^ g[GAIN_W-1];
        rounded  = ((80'(acc_mag) * 80'(gain_mag)) + (80'd1 << 35)) >> 36;
        if (neg) begin
            return (rounded >= 80'h8000_0000) ? 32'h8000_0000 : (32'd0 - rounded[31:0]);
        end
        return (rounded > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
    endfunction

    // filter predictor: one accepted transaction in, at most one window sum out
    task automatic apply_filter_item(input wcg_kind_t kind, input logic [INDEX_W-1:0] idx,
                                     input logic [COEF_W-1:0] coef,
                                     input logic [SAMPLE_W-1:0] smp, input bit undef,
                                     output bit emits, output window_result_t res);
        int unsigned        cells;
        logic signed [43:0] prod;
        emits = 1'b0;
        res   = '0;
        if (kind == KIND_COEF) begin
            if (idx < STORE_DEPTH) begin
                kernel_store[idx] = coef;
            end
        end else begin
            cells = side_used(rows_model) * side_used(cols_model);
            if (undef) begin
                window_undef = 1'b1;
            end else if (!window_undef) begin
                prod       = $signed(smp) * $signed(kernel_store[window_pos]);
                window_acc = window_acc + {{(ACC_W-44){prod[43]}}, prod};
            end
            if (window_pos + 1 >= cells) begin
                emits      = 1'b1;
                res.undef  = window_undef;
                res.value  = window_undef ? '0 : scale_window_sum(window_acc, gain_model);
                window_acc   = '0;
                window_pos   = 0;
                window_undef = 1'b0;
            end else begin
                window_pos++;
            end
        end
    endtask

    // random field values, weighted toward the extremes
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return SAMPLE_W'($urandom_range(0, 510)) - SAMPLE_W'(255);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 20'h7_FFFF;
            1:       return 20'h8_0000;
            2:       return COEF_W'($urandom_range(0, 131072)) - COEF_W'(65536);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // offer one input transaction, wait for acceptance, then predict
    task automatic offer_item(input wcg_kind_t kind, input logic [INDEX_W-1:0] idx,
                              input logic [COEF_W-1:0] coef, input logic [SAMPLE_W-1:0] smp,
                              input bit undef, input bit typed, input window_result_t typed_res);
        int unsigned          gap;
        bit                   emits;
        window_result_t       predicted;
        logic [S_TDATA_W-1:0] data;
        gap = 0;
        if (source_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        data = '0;
        data[OFS_INDEX +: INDEX_W]   = idx;
        data[OFS_COEF +: COEF_W]     = coef;
        data[OFS_SAMPLE +: SAMPLE_W] = smp;
        data[OFS_UNDEF]              = undef;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        apply_filter_item(kind, idx, coef, smp, undef, emits, predicted);
        if (typed) begin
            window_sums_due.push_back(typed_res);
        end else if (emits) begin
            window_sums_due.push_back(predicted);
        end
    endtask

    // stop offering, wait for every expected sum, then let the pipeline settle
    task automatic let_results_drain();
        s_tvalid <= 1'b0;
        while (window_sums_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three registers back to back while the block is idle
    task automatic program_filter(input logic [SIDE_REG_W-1:0] rows,
                                  input logic [SIDE_REG_W-1:0] cols,
                                  input logic [GAIN_W-1:0] g);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_KERNEL_ROWS;
        cfg_wr_data  <= CFG_DATA_W'(rows);
        @(posedge aclk);
        cfg_wr_index <= REG_KERNEL_COLUMNS;
        cfg_wr_data  <= CFG_DATA_W'(cols);
        @(posedge aclk);
        cfg_wr_index <= REG_GAIN;
        cfg_wr_data  <= g;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        rows_model = rows;
        cols_model = cols;
        gain_model = g;
    endtask

    task automatic log_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // result side: check each transaction, drive tready with random stalls
    initial begin : result_sink
        int unsigned    low_left;
        window_result_t want;
        low_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (window_sums_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result: value %h undefined %b",
                                           m_tdata, m_tuser));
                end else begin
                    want = window_sums_due.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.undef) begin
                        log_mismatch($sformatf(
                            "result mismatch: value exp %h act %h, undefined exp %b act %b",
                            want.value, m_tdata, want.undef, m_tuser));
                    end
                end
            end
            if (low_left > 0) begin
                low_left--;
                m_tready <= 1'b0;
            end else if (hold_results) begin
                hold_results = 1'b0;
                low_left     = LONG_HOLD_CYCLES - 1;
                m_tready     <= 1'b0;
            end else if (sink_idling && $urandom_range(0, 11) == 0) begin
                low_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transaction on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        int                    p;
        int                    i;
        logic [SIDE_REG_W-1:0] r_rows;
        logic [SIDE_REG_W-1:0] r_cols;
        logic [GAIN_W-1:0]     r_gain;
        int unsigned           pick;
        window_result_t        typed_res;

        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= KIND_COEF;
        m_tready     <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;
        aresetn      <= 1'b0;
        error_count   = 0;
        hold_results  = 1'b0;
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        window_acc    = '0;
        window_pos    = 0;
        window_undef  = 1'b0;
        rows_model    = ROWS_RESET;
        cols_model    = COLUMNS_RESET;
        gain_model    = GAIN_RESET;
        for (i = 0; i < STORE_DEPTH; i++) begin
            kernel_store[i] = '0;
        end

        // reset kernel is 3x3 at unit gain; coefficients at 1.0 pass the sample through
        directed_rows = '{
            '{KIND_COEF,   6'd0,  20'h1_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd1,  20'h7_FFFF, 24'h7F_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd2,  20'h8_0000, 24'h80_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd3,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd4,  20'h1_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd5,  20'hF_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd6,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd7,  20'h0_8000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_COEF,   6'd8,  20'h0_0001, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            // load past the end of the store is dropped
            '{KIND_COEF,   6'd63, 20'h7_FFFF, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            // extreme samples cancel on the unit taps: sum is -1
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h7F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h7F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h80_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h80_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
            // undefined sample mid-window poisons the rest of the window
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_03E8, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h7F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h80_0000, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0005, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h12_3456, 1'b1, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0007, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h7F_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0009, 1'b0, 1'b0, 32'h0, 1'b0},
            '{KIND_SAMPLE, 6'd0,  20'h0_0000, 24'h00_0064, 1'b0, 1'b1, 32'h0, 1'b1}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            typed_res.value = directed_rows[i].want_value;
            typed_res.undef = directed_rows[i].want_undef;
            offer_item(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].coef,
                       directed_rows[i].smp, directed_rows[i].undef, directed_rows[i].typed,
                       typed_res);
        end

        // fill the whole store so every window position reads a written entry
        for (i = 0; i < STORE_DEPTH; i++) begin
            offer_item(KIND_COEF, INDEX_W'(i), rand_coef(), rand_sample(),
                       1'($urandom), 1'b0, '0);
        end

        // random phases over kernel shapes and gains
        for (p = 0; p < NUM_PHASES; p++) begin
            let_results_drain();
            case (p)
                0: begin
                    r_rows = 3'd0; r_cols = 3'd0; r_gain = 24'h7F_FFFF;
                end
                1: begin
                    r_rows = 3'd7; r_cols = 3'd7; r_gain = 24'h80_0000;
                end
                2: begin
                    r_rows = 3'd2; r_cols = 3'd5; r_gain = 24'h10_0000;
                end
                4: begin
                    r_rows = 3'd1; r_cols = 3'd7; r_gain = 24'h00_0000;
                end
                default: begin
                    r_rows = SIDE_REG_W'($urandom);
                    r_cols = SIDE_REG_W'($urandom);
                    r_gain = GAIN_W'($urandom_range(0, 24'h3F_FFFF)) - GAIN_W'(24'h20_0000);
                end
            endcase
            program_filter(r_rows, r_cols, r_gain);
            source_idling = (p != 3) && (p != NUM_PHASES - 1);
            sink_idling   = source_idling;
            // single-sample windows at full gain: hold the result side to back up the input
            if (p == 0) begin
                hold_results = 1'b1;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    offer_item(KIND_COEF, INDEX_W'($urandom_range(0, STORE_DEPTH - 1)),
                               rand_coef(), rand_sample(), 1'($urandom), 1'b0, '0);
                end else if (pick < 8) begin
                    offer_item(KIND_COEF, INDEX_W'($urandom_range(STORE_DEPTH, 63)),
                               rand_coef(), rand_sample(), 1'($urandom), 1'b0, '0);
                end else begin
                    offer_item(KIND_SAMPLE, INDEX_W'($urandom), rand_coef(), rand_sample(),
                               ($urandom_range(0, 79) == 0), 1'b0, '0);
                end
            end
        end

        let_results_drain();
        if (error_count == 0 && window_sums_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/wcg_pkg.sv
rtl/core/wcg_front.sv
rtl/core/wcg_queue.sv
rtl/core/wcg_back.sv
rtl/core/wcg_scale.sv
rtl/core/window_convolution_with_gain_unit.sv
verif/tb_window_convolution_with_gain_unit.sv
